// ===== rtl/core/key_interning_bit_index_table_assert.svh =====
// Assertion macros for the key interning table RTL.
`ifndef KEY_INTERNING_BIT_INDEX_TABLE_ASSERT_SVH
`define KEY_INTERNING_BIT_INDEX_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define KIBIT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`else
`define KIBIT_ASSERT(label, clk, rst_n, prop)
`endif

`ifndef SYNTHESIS
`define KIBIT_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define KIBIT_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ===== rtl/core/kibit_pkg.sv =====
// Package: shared constants of the key interning table.
package kibit_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int KEY_WIDTH_DEF   = 64;

    localparam int KEY_FIELD_W = 64;
    localparam int CAP_W       = 9;
    localparam int BYTE_W      = 5;
    localparam int MASK_W      = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

endpackage

// ===== rtl/core/key_interning_bit_index_table.sv =====
// Top level: key interning table giving each key a dense bitset position.
// Use: one key per item arrives on the s_axis channel (tdata = key). The
// block searches its stored keys one entry per cycle through a single
// compare unit fed by the key memory. A key found at entry i answers with
// byte i/8 and one-hot mask 1 << (i%8). A new key is appended when the
// count is below min(capacity, MAX_ENTRIES); otherwise status full is
// returned with byte and mask zero. A zero key answers all zeros and is
// not stored. Each result goes out on m_axis: tdata = byte_index, bit_mask;
// tuser = status.
// The memory read port, one entry per cycle, paces the search: a found key
// ends it at its entry, a new or refused key after every stored entry, and
// a zero key skips it. One item is in work at a time: tready is low from
// accept until the result has moved to the output register, and only then
// is the next item taken.
// Reset clears the entry count and sets the capacity to 256; the memory
// needs no clearing, as only entries below the count are read.
// A stalled receiver holds the result in the output register; a finished search
// then waits, and no new item is taken meanwhile. The user must write the capacity
// register via i_cfg_we / i_cfg_wdata only while idle; the block does not enforce it.
`include "key_interning_bit_index_table_assert.svh"

module key_interning_bit_index_table #(
    parameter int MAX_ENTRIES = kibit_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_WIDTH   = kibit_pkg::KEY_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration: capacity_in_use
    input  logic                                i_cfg_we,
    input  logic [kibit_pkg::CAP_W-1:0]         i_cfg_wdata,
    // Input items
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [kibit_pkg::KEY_FIELD_W-1:0]   i_s_axis_tdata,  // [63:0] key
    // Result items
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [kibit_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,  // [4:0] byte_index,
                                                                 // [12:5] bit_mask, pad
    output logic                                o_m_axis_tuser   // [0] status
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = (CW > kibit_pkg::CAP_W) ? CW : kibit_pkg::CAP_W;
    localparam int BW = kibit_pkg::BYTE_W;
    localparam int MW = kibit_pkg::MASK_W;
    localparam int PAD_W = kibit_pkg::OUT_TDATA_W - BW - MW;

    localparam logic [LW-1:0] MAX_EXT = LW'(MAX_ENTRIES);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    // Bitset position of an entry index.
    function automatic logic [BW-1:0] f_byte(input logic [AW-1:0] idx);
        logic [AW+BW-1:0] ext;
        ext = {{BW{1'b0}}, idx};
        return ext[BW+2:3];
    endfunction

    function automatic logic [MW-1:0] f_mask(input logic [AW-1:0] idx);
        return MW'(1) << idx[2:0];
    endfunction

    logic [1:0]                 r_state,      n_state;
    logic [KEY_WIDTH-1:0]       r_key,        n_key;
    logic [CW-1:0]              r_idx,        n_idx;
    logic                       r_pend,       n_pend;
    logic [AW-1:0]              r_pend_idx,   n_pend_idx;
    logic [CW-1:0]              r_count,      n_count;
    logic [kibit_pkg::CAP_W-1:0] r_cap,       n_cap;
    logic [BW-1:0]              r_res_byte,   n_res_byte;
    logic [MW-1:0]              r_res_mask,   n_res_mask;
    logic                       r_res_status, n_res_status;
    logic                       r_out_valid,  n_out_valid;
    logic [BW-1:0]              r_out_byte,   n_out_byte;
    logic [MW-1:0]              r_out_mask,   n_out_mask;
    logic                       r_out_status, n_out_status;

    logic [KEY_WIDTH-1:0] in_key;
    logic [KEY_WIDTH-1:0] rd_data;
    logic                 rd_en;
    logic                 wr_en;
    logic                 hit;
    logic [LW-1:0]        cap_ext;
    logic [LW-1:0]        limit;
    logic                 full;

    assign in_key  = i_s_axis_tdata[KEY_WIDTH-1:0];
    assign hit     = r_pend && (rd_data == r_key);
    assign cap_ext = LW'(r_cap);
    assign limit   = (cap_ext > MAX_EXT) ? MAX_EXT : cap_ext;
    assign full    = (LW'(r_count) >= limit);

    kibit_store #(
        .DEPTH  (MAX_ENTRIES),
        .DATA_W (KEY_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_key),
        .i_re    (rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_count      = r_count;
        n_cap        = r_cap;
        n_res_byte   = r_res_byte;
        n_res_mask   = r_res_mask;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_mask   = r_out_mask;
        n_out_status = r_out_status;
        rd_en        = 1'b0;
        wr_en        = 1'b0;

        if (i_cfg_we) begin
            n_cap = i_cfg_wdata;
        end

        // Drop the held result once the receiver takes it.
        if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_key  = in_key;
                    n_idx  = '0;
                    n_pend = 1'b0;
                    if (in_key == '0) begin
                        // Null key: answer zeros, store nothing.
                        n_res_byte   = '0;
                        n_res_mask   = '0;
                        n_res_status = 1'b0;
                        n_state      = ST_DONE;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    n_pend       = 1'b0;
                    n_res_byte   = f_byte(r_pend_idx);
                    n_res_mask   = f_mask(r_pend_idx);
                    n_res_status = 1'b0;
                    n_state      = ST_DONE;
                end else if (r_idx == r_count) begin
                    // Every stored entry compared without a match.
                    n_pend = 1'b0;
                    if (full) begin
                        n_res_byte   = '0;
                        n_res_mask   = '0;
                        n_res_status = 1'b1;
                    end else begin
                        wr_en        = 1'b1;
                        n_count      = r_count + CW'(1);
                        n_res_byte   = f_byte(r_count[AW-1:0]);
                        n_res_mask   = f_mask(r_count[AW-1:0]);
                        n_res_status = 1'b0;
                    end
                    n_state = ST_DONE;
                end else begin
                    // Advance: issue the next read and compare its data in the following cycle.
                    rd_en      = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[AW-1:0];
                    n_idx      = r_idx + CW'(1);
                end
            end
            ST_DONE: begin
                // Hold until the output register is free.
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = r_res_byte;
                    n_out_mask   = r_res_mask;
                    n_out_status = r_res_status;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_cap       <= kibit_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_pend_idx   <= n_pend_idx;
        r_res_byte   <= n_res_byte;
        r_res_mask   <= n_res_mask;
        r_res_status <= n_res_status;
        r_out_byte   <= n_out_byte;
        r_out_mask   <= n_out_mask;
        r_out_status <= n_out_status;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_out_mask, r_out_byte};
    assign o_m_axis_tuser  = r_out_status;

    // The count moves only at the end of a search, and by one.
    `KIBIT_ASSERT(a_count_step, i_clk, i_rst_n,
        (r_count != $past(r_count)) |->
            (($past(r_state) == ST_SEARCH) && (r_count == $past(r_count) + CW'(1))))
    // A full report never carries a bit position.
    `KIBIT_ASSERT_NEVER(a_full_no_mask, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser && (o_m_axis_tdata != '0))
    // After an accept the block is busy in the next cycle.
    `KIBIT_ASSERT(a_busy_after_accept, i_clk, i_rst_n,
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
    // A result bit position is one-hot or empty.
    `KIBIT_ASSERT(a_mask_onehot, i_clk, i_rst_n,
        o_m_axis_tvalid |-> $onehot0(r_out_mask))

endmodule

// ===== rtl/core/kibit_store.sv =====
// Key store: single-port-write, single-port-read memory with registered read data.
module kibit_store #(
    parameter int DEPTH  = kibit_pkg::MAX_ENTRIES_DEF,
    parameter int DATA_W = kibit_pkg::KEY_WIDTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/sv/key_interning_bit_index_table_tb.sv =====
// Testbench: self-checking stream test of the key interning bit index table.
module key_interning_bit_index_table_tb;

    localparam int TABLE_DEPTH = kibit_pkg::MAX_ENTRIES_DEF;
    // Slowest run: ~1100 keys at full search depth, stalls and gaps included.
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [kibit_pkg::BYTE_W-1:0] byte_index;
        logic [kibit_pkg::MASK_W-1:0] bit_mask;
        logic                         status;
    } t_bit_position;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [kibit_pkg::CAP_W-1:0]       i_cfg_wdata = '0;
    logic                              i_s_axis_tvalid = 1'b0;
    logic                              o_s_axis_tready;
    logic [kibit_pkg::KEY_FIELD_W-1:0] i_s_axis_tdata = '0;  // [63:0] key
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready = 1'b0;
    // [4:0] byte_index, [12:5] bit_mask, pad
    logic [kibit_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                              o_m_axis_tuser;       // [0] status

    // Predictor state: interned keys in order of assignment, and the capacity.
    logic [kibit_pkg::KEY_FIELD_W-1:0] interned_keys[$];
    int                                capacity_limit = kibit_pkg::CAP_RESET;
    t_bit_position                     expected_positions[$];

    int  cycle_count = 0;
    int  error_count = 0;
    int  keys_sent = 0;
    int  results_checked = 0;
    int  full_replies = 0;
    int  holdoff_left = 0;
    bit  steady_flow = 1'b0;

    key_interning_bit_index_table u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: stop a hung run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Work out the bitset position of a key and intern it when there is room.
    function automatic t_bit_position intern_key(
        input logic [kibit_pkg::KEY_FIELD_W-1:0] key);
        t_bit_position pos;
        int            slot;
        int            limit;
        pos  = '0;
        slot = -1;
        if (key == '0) return pos;
        for (int i = 0; i < interned_keys.size(); i++) begin
            if (interned_keys[i] == key) begin
                slot = i;
                break;
            end
        end
        if (slot < 0) begin
            limit = (capacity_limit > TABLE_DEPTH) ? TABLE_DEPTH : capacity_limit;
            if (interned_keys.size() >= limit) begin
                pos.status = 1'b1;
                return pos;
            end
            interned_keys.push_back(key);
            slot = interned_keys.size() - 1;
        end
        pos.byte_index = kibit_pkg::BYTE_W'(slot / 8);
        pos.bit_mask   = kibit_pkg::MASK_W'(1 << (slot % 8));
        return pos;
    endfunction

    // Receiver: random stalls, a steady stretch, and a counted hold-off on request.
    always @(posedge i_clk) begin
        if (holdoff_left > 0) begin
            holdoff_left    <= holdoff_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (steady_flow) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= 32);
        end
    end

    // Check each result item against the oldest expected position.
    always @(posedge i_clk) begin
        t_bit_position want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_positions.size() == 0) begin
                error_count++;
                $display("%0t: result with nothing expected, actual tdata %h tuser %b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                want = expected_positions.pop_front();
                results_checked++;
                if (o_m_axis_tdata[4:0] !== want.byte_index) begin
                    error_count++;
                    $display("%0t: byte_index mismatch, expected %0d actual %0d",
                             $time, want.byte_index, o_m_axis_tdata[4:0]);
                end
                if (o_m_axis_tdata[12:5] !== want.bit_mask) begin
                    error_count++;
                    $display("%0t: bit_mask mismatch, expected %h actual %h",
                             $time, want.bit_mask, o_m_axis_tdata[12:5]);
                end
                if (o_m_axis_tdata[15:13] !== 3'b000) begin
                    error_count++;
                    $display("%0t: tdata pad mismatch, expected 0 actual %b",
                             $time, o_m_axis_tdata[15:13]);
                end
                if (o_m_axis_tuser !== want.status) begin
                    error_count++;
                    $display("%0t: status mismatch, expected %b actual %b",
                             $time, want.status, o_m_axis_tuser);
                end
            end
        end
    end

    // Offer one key, with an optional random gap first; leave tvalid high after the
    // handshake so that back-to-back items need no second assignment in one step.
    task automatic send_key(input logic [kibit_pkg::KEY_FIELD_W-1:0] key);
        int gap;
        gap = 0;
        if (!steady_flow) begin
            while ($urandom_range(99) < 32) gap++;
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= key;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_positions.push_back(intern_key(key));
        keys_sent++;
        if (expected_positions[$].status) full_replies++;
    endtask

    // Hold the sender until every expected result has come back.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (expected_positions.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input int value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= kibit_pkg::CAP_W'(value);
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        capacity_limit = value;
    endtask

    function automatic logic [kibit_pkg::KEY_FIELD_W-1:0] random_key();
        logic [kibit_pkg::KEY_FIELD_W-1:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(3))
            0: k = k >> $urandom_range(63);   // narrow keys
            1: k = k | (64'h1 << 63);
            default: ;
        endcase
        return k;
    endfunction

    // Mix of null keys, new keys and repeats of interned keys.
    task automatic run_random_keys(input int count, input int new_pct);
        logic [kibit_pkg::KEY_FIELD_W-1:0] k;
        int                                pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 8)
                k = '0;
            else if (pick < 8 + new_pct || interned_keys.size() == 0)
                k = random_key();
            else
                k = interned_keys[$urandom_range(interned_keys.size() - 1)];
            send_key(k);
        end
    endtask

    // Null keys, extreme keys, repeats, and the first byte boundary.
    task automatic test_first_keys();
        send_key(64'h0);
        send_key(64'hFFFF_FFFF_FFFF_FFFF);
        send_key(64'h1);
        send_key(64'h8000_0000_0000_0000);
        send_key(64'hFFFF_FFFF_FFFF_FFFF);
        send_key(64'h0);
        send_key(64'hAAAA_AAAA_AAAA_AAAA);
        send_key(64'h5555_5555_5555_5555);
        send_key(64'h0000_0001_0000_0000);
        send_key(64'h0000_0000_8000_0000);
        send_key(64'h1234_5678_9ABC_DEF0);
        send_key(64'h0000_0000_0000_0002);
        send_key(64'h1);
    endtask

    // Capacity at zero, at the count and one above it.
    task automatic test_capacity_edges();
        write_capacity(0);
        send_key(64'hDEAD_BEEF_0000_0001);   // new key, refused
        send_key(64'h8000_0000_0000_0000);   // stored key still found
        send_key(64'h0);
        write_capacity(interned_keys.size());
        send_key(64'hDEAD_BEEF_0000_0002);   // refused exactly at the limit
        write_capacity(interned_keys.size() + 1);
        send_key(64'hDEAD_BEEF_0000_0003);   // takes the last slot
        send_key(64'hDEAD_BEEF_0000_0004);   // refused again
    endtask

    // Fill the table through several capacities, up to the full depth.
    task automatic test_random_capacities();
        write_capacity(48);
        run_random_keys(180, 40);
        write_capacity(0);
        run_random_keys(60, 40);
        write_capacity(1);
        run_random_keys(40, 40);
        write_capacity(130);
        run_random_keys(200, 45);
        // Run flat out through the full table, with the clamp above the depth.
        steady_flow = 1'b1;
        write_capacity(511);
        run_random_keys(300, 60);
        steady_flow = 1'b0;
        write_capacity(256);
        run_random_keys(150, 30);
    endtask

    // Hold the receiver off while keys keep coming, so that the input stalls;
    // the stretch outlasts two full-depth searches.
    task automatic test_receiver_holdoff();
        holdoff_left <= 2000;
        @(posedge i_clk);
        steady_flow = 1'b1;
        run_random_keys(16, 30);
        steady_flow = 1'b0;
    endtask

    // Pause the sender until everything is back, then carry on.
    task automatic test_sender_pause();
        run_random_keys(50, 30);
        wait_drained();
        run_random_keys(50, 30);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_first_keys();
        test_capacity_edges();
        test_random_capacities();
        test_receiver_holdoff();
        test_sender_pause();
        wait_drained();
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        $display("Sent %0d keys, checked %0d results, %0d refused as full.",
                 keys_sent, results_checked, full_replies);
        $display("Table ended with %0d keys; capacities 0, 1, 48, 130, 256 and 511 used.",
                 interned_keys.size());
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
